### hdl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants, codes and transaction types of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int MAX_WIDTH      = 2048;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int ROW_BITS       = 16;
   localparam int FW_BITS        = 12;
   localparam int FH_BITS        = 16;
   localparam int PIX_BITS       = 8;
   localparam int PEND_BITS      = $clog2(MAX_WIDTH + 2);
   localparam int CMP_BITS       = ((COL_BITS > FW_BITS) ? COL_BITS : FW_BITS) + 1;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int OUT_DEPTH      = 8;
   localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS   = $clog2(OUT_DEPTH + 1);

   localparam int BACK_LATENCY     = 4;
   localparam int OUT_CREDIT_LIMIT = OUT_DEPTH - BACK_LATENCY - 1;

   localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET  = FW_BITS'(640);
   localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RESET = FH_BITS'(480);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_reg_type;

   typedef enum logic {
      MODE_PIXEL = 1'b0,
      MODE_FLUSH = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type              kind;
      logic [COL_BITS-1:0]   addr;
      logic [PIX_BITS-1:0]   pixel;
      logic                  emit;
      logic                  use_median;
      logic                  sel_lower;
      logic                  last;
   } op_type;

   typedef struct packed {
      logic [PIX_BITS-1:0]   pixel;
      logic                  frame_end;
   } result_type;

   typedef struct packed {
      logic                      not_empty;
      logic                      full;
      logic [QUEUE_CNT_BITS-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic                      not_empty;
      logic [OUT_CNT_BITS-1:0]   count;
   } out_status_type;

endpackage

### hdl/median_filter_3x3.sv
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter for 8-bit raster frames, border pixels pass.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_stall    req_mode, req_pixel_in
//   rsp      out  rsp_valid/rsp_stall    rsp_pixel_out, rsp_frame_end
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// One item per clock while req_stall is low; a result is offered once its item
// has passed the row-store read, three median stages and the result buffer.
// Synchronous reset clears counters, window and buffers and loads 640x480;
// the row stores are not cleared.
// rsp_stall fills the 8-entry result buffer, the back end then stops pulling
// from the 4-entry operation queue, and a full queue raises req_stall.
// ----------------------------------------------------------------------------
module median_filter_3x3 (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic [mf3_pkg::PIX_BITS-1:0]          req_pixel_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mf3_pkg::PIX_BITS-1:0]          rsp_pixel_out,
   output logic                                  rsp_frame_end,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mf3_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mf3_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   logic                         front_push;
   mf3_pkg::op_type              front_op;
   mf3_pkg::queue_status_type    q_status;
   mf3_pkg::op_type              q_head;
   logic                         back_pop;
   logic                         back_push;
   mf3_pkg::result_type          back_result;
   mf3_pkg::out_status_type      out_status;
   mf3_pkg::result_type          out_head;
   logic                         out_pop;

   mf3_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_pixel_in (req_pixel_in),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .q_status     (q_status),
      .push         (front_push),
      .push_op      (front_op)
   );

   mf3_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .push_op (front_op),
      .pop     (back_pop),
      .head_op (q_head),
      .status  (q_status)
   );

   mf3_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .q_head      (q_head),
      .pop         (back_pop),
      .out_status  (out_status),
      .push        (back_push),
      .push_result (back_result)
   );

   mf3_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .push        (back_push),
      .push_result (back_result),
      .pop         (out_pop),
      .head_result (out_head),
      .status      (out_status)
   );

   assign rsp_valid     = out_status.not_empty;
   assign out_pop       = rsp_valid && !rsp_stall;
   assign rsp_pixel_out = out_head.pixel;
   assign rsp_frame_end = out_head.frame_end;

   // credit check keeps every result in flight within the buffer
   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      back_push |-> (out_status.count != mf3_pkg::OUT_CNT_BITS'(mf3_pkg::OUT_DEPTH)))
      else $error("result buffer overflow");

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      front_push |-> !q_status.full)
      else $error("operation queue overflow");

   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      back_pop |-> q_status.not_empty)
      else $error("back end pulled from an empty queue");

endmodule

### hdl/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         // write-through on a same-address collision
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/mf3_front.sv
// ----------------------------------------------------------------------------
// mf3_front
// Input side: frame geometry registers, raster counters and item
// classification into pixel and flush operations for the back end.
// ----------------------------------------------------------------------------
module mf3_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic [mf3_pkg::PIX_BITS-1:0]          req_pixel_in,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mf3_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mf3_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  mf3_pkg::queue_status_type             q_status,
   output logic                                  push,
   output mf3_pkg::op_type                       push_op
);

   logic [mf3_pkg::FW_BITS-1:0]   frame_width_ff;
   logic [mf3_pkg::FH_BITS-1:0]   frame_height_ff;
   logic [mf3_pkg::COL_BITS-1:0]  in_col_ff, in_col_in;
   logic [mf3_pkg::ROW_BITS-1:0]  in_row_ff, in_row_in;
   logic [mf3_pkg::COL_BITS-1:0]  out_col_ff, out_col_in;
   logic [mf3_pkg::ROW_BITS-1:0]  out_row_ff, out_row_in;
   logic [mf3_pkg::PEND_BITS-1:0] pending_ff, pending_in;

   logic [mf3_pkg::FW_BITS-1:0]   weff;
   logic [mf3_pkg::FH_BITS-1:0]   heff;
   logic                          accept;
   logic                          in_col_end;
   logic                          in_row_end;
   logic                          out_col_end;
   logic                          out_row_last;
   logic                          emit;
   logic                          use_median;
   logic [mf3_pkg::PEND_BITS-1:0] pend_load;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= mf3_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= mf3_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mf3_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_data[mf3_pkg::FW_BITS-1:0];
            end
            mf3_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_data[mf3_pkg::FH_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      weff = frame_width_ff;
      if (frame_width_ff == '0) begin
         weff = mf3_pkg::FW_BITS'(1);
      end else if (32'(frame_width_ff) > mf3_pkg::MAX_WIDTH) begin
         weff = mf3_pkg::FW_BITS'(mf3_pkg::MAX_WIDTH);
      end
   end

   assign heff = (frame_height_ff == '0) ? mf3_pkg::FH_BITS'(1) : frame_height_ff;

   assign in_col_end   = (mf3_pkg::CMP_BITS'(in_col_ff) + mf3_pkg::CMP_BITS'(1))
                         >= mf3_pkg::CMP_BITS'(weff);
   assign out_col_end  = (mf3_pkg::CMP_BITS'(out_col_ff) + mf3_pkg::CMP_BITS'(1))
                         >= mf3_pkg::CMP_BITS'(weff);
   assign in_row_end   = ({1'b0, in_row_ff} + (mf3_pkg::ROW_BITS + 1)'(1))
                         >= {1'b0, heff};
   assign out_row_last = ({1'b0, out_row_ff} + (mf3_pkg::ROW_BITS + 1)'(1))
                         >= {1'b0, heff};

   assign emit = (in_row_ff > mf3_pkg::ROW_BITS'(1)) ||
                 ((in_row_ff == mf3_pkg::ROW_BITS'(1)) && (in_col_ff != '0));
   assign use_median = (in_row_ff > mf3_pkg::ROW_BITS'(1)) &&
                       (in_col_ff > mf3_pkg::COL_BITS'(1)) &&
                       (in_row_ff < heff) &&
                       (mf3_pkg::CMP_BITS'(in_col_ff) < mf3_pkg::CMP_BITS'(weff));
   assign pend_load = mf3_pkg::PEND_BITS'(weff) +
                      ((heff == mf3_pkg::FH_BITS'(1)) ? '0 : mf3_pkg::PEND_BITS'(1));

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pending_in = pending_ff;
      push       = 1'b0;
      push_op    = '0;
      if (accept) begin
         if (req_mode == mf3_pkg::MODE_FLUSH) begin
            if (pending_ff != '0) begin
               push               = 1'b1;
               push_op.kind       = mf3_pkg::MODE_FLUSH;
               push_op.addr       = out_col_ff;
               push_op.emit       = 1'b1;
               push_op.sel_lower  = out_row_last;
               push_op.last       = (pending_ff == mf3_pkg::PEND_BITS'(1));
               pending_in         = pending_ff - mf3_pkg::PEND_BITS'(1);
               if (out_col_end) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + mf3_pkg::ROW_BITS'(1);
               end else begin
                  out_col_in = out_col_ff + mf3_pkg::COL_BITS'(1);
               end
               if (pending_ff == mf3_pkg::PEND_BITS'(1)) begin
                  out_col_in = '0;
                  out_row_in = '0;
               end
            end
         end else if (pending_ff == '0) begin
            push               = 1'b1;
            push_op.kind       = mf3_pkg::MODE_PIXEL;
            push_op.addr       = in_col_ff;
            push_op.pixel      = req_pixel_in;
            push_op.emit       = emit;
            push_op.use_median = use_median;
            if (emit) begin
               if (out_col_end) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + mf3_pkg::ROW_BITS'(1);
               end else begin
                  out_col_in = out_col_ff + mf3_pkg::COL_BITS'(1);
               end
            end
            if (in_col_end) begin
               in_col_in = '0;
               if (in_row_end) begin
                  in_row_in  = '0;
                  pending_in = pend_load;
               end else begin
                  in_row_in = in_row_ff + mf3_pkg::ROW_BITS'(1);
               end
            end else begin
               in_col_in = in_col_ff + mf3_pkg::COL_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pending_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pending_ff <= pending_in;
      end
   end

endmodule

### hdl/mf3_queue.sv
// ----------------------------------------------------------------------------
// mf3_queue
// Short operation queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mf3_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mf3_pkg::op_type           push_op,
   input  logic                      pop,
   output mf3_pkg::op_type           head_op,
   output mf3_pkg::queue_status_type status
);

   mf3_pkg::op_type                     entry_ff [mf3_pkg::QUEUE_DEPTH];
   logic [mf3_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [mf3_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [mf3_pkg::QUEUE_CNT_BITS-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mf3_pkg::QUEUE_PTR_BITS'(mf3_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + mf3_pkg::QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mf3_pkg::QUEUE_PTR_BITS'(mf3_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + mf3_pkg::QUEUE_PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + mf3_pkg::QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - mf3_pkg::QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head_op          = entry_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == mf3_pkg::QUEUE_CNT_BITS'(mf3_pkg::QUEUE_DEPTH));
   assign status.count     = count_ff;

endmodule

### hdl/mf3_back.sv
// ----------------------------------------------------------------------------
// mf3_back
// Execution side: row stores, 3x3 window and a pipelined median network.
// Pulls operations only when the result buffer has room for all in flight.
// ----------------------------------------------------------------------------
module mf3_back (
   input  logic                        clock,
   input  logic                        reset,
   input  mf3_pkg::queue_status_type   q_status,
   input  mf3_pkg::op_type             q_head,
   output logic                        pop,
   input  mf3_pkg::out_status_type     out_status,
   output logic                        push,
   output mf3_pkg::result_type         push_result
);

   typedef logic [mf3_pkg::PIX_BITS-1:0] pix_type;

   typedef struct packed {
      pix_type lo;
      pix_type mid;
      pix_type hi;
   } trio_type;

   function automatic pix_type min2(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type max2(input pix_type a, input pix_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic trio_type sort3(input pix_type a, input pix_type b, input pix_type c);
      trio_type r;
      r.lo  = min2(min2(a, b), c);
      r.hi  = max2(max2(a, b), c);
      r.mid = med3(a, b, c);
      return r;
   endfunction

   logic                 s1_valid_ff;
   mf3_pkg::op_type      s1_op_ff;
   pix_type              upper_rd, lower_rd;
   logic                 s1_pixel;

   pix_type              win_ff [9];
   pix_type              win_in [9];

   logic                 s2_valid_ff, s2_med_ff, s2_last_ff;
   pix_type              s2_pass_ff, s2_pass_in;

   logic                 s3_valid_ff, s3_med_ff, s3_last_ff;
   pix_type              s3_pass_ff;
   trio_type             s3_row_ff [3];

   logic                 s4_valid_ff, s4_med_ff, s4_last_ff;
   pix_type              s4_pass_ff;
   pix_type              s4_lo_ff, s4_mid_ff, s4_hi_ff;

   assign pop = q_status.not_empty &&
                (out_status.count <= mf3_pkg::OUT_CNT_BITS'(mf3_pkg::OUT_CREDIT_LIMIT));

   assign s1_pixel = s1_valid_ff && (s1_op_ff.kind == mf3_pkg::MODE_PIXEL);

   mf3_ram #(
      .WIDTH (mf3_pkg::PIX_BITS),
      .DEPTH (mf3_pkg::MAX_WIDTH)
   ) u_row_upper (
      .clock   (clock),
      .wr_en   (s1_pixel),
      .wr_addr (s1_op_ff.addr),
      .wr_data (lower_rd),
      .rd_en   (pop),
      .rd_addr (q_head.addr),
      .rd_data (upper_rd)
   );

   mf3_ram #(
      .WIDTH (mf3_pkg::PIX_BITS),
      .DEPTH (mf3_pkg::MAX_WIDTH)
   ) u_row_lower (
      .clock   (clock),
      .wr_en   (s1_pixel),
      .wr_addr (s1_op_ff.addr),
      .wr_data (s1_op_ff.pixel),
      .rd_en   (pop),
      .rd_addr (q_head.addr),
      .rd_data (lower_rd)
   );

   // stage 1: read data back, shift window, write stores
   always_comb begin
      win_in = win_ff;
      if (s1_pixel) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = upper_rd;
         win_in[3] = win_ff[4];
         win_in[4] = win_ff[5];
         win_in[5] = lower_rd;
         win_in[6] = win_ff[7];
         win_in[7] = win_ff[8];
         win_in[8] = s1_op_ff.pixel;
      end
      if (s1_op_ff.kind == mf3_pkg::MODE_PIXEL) begin
         s2_pass_in = win_ff[5];
      end else if (s1_op_ff.sel_lower) begin
         s2_pass_in = lower_rd;
      end else begin
         s2_pass_in = upper_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff <= pop;
         s2_valid_ff <= s1_valid_ff && s1_op_ff.emit;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff   <= q_head;
      s2_med_ff  <= s1_pixel && s1_op_ff.use_median;
      s2_last_ff <= s1_op_ff.last;
      s2_pass_ff <= s2_pass_in;
      // stage 2: sort each window row
      for (int r = 0; r < 3; r++) begin
         s3_row_ff[r] <= sort3(win_ff[3 * r], win_ff[3 * r + 1], win_ff[3 * r + 2]);
      end
      s3_med_ff  <= s2_med_ff;
      s3_last_ff <= s2_last_ff;
      s3_pass_ff <= s2_pass_ff;
      // stage 3: max of lows, median of middles, min of highs
      s4_lo_ff   <= max2(max2(s3_row_ff[0].lo, s3_row_ff[1].lo), s3_row_ff[2].lo);
      s4_mid_ff  <= med3(s3_row_ff[0].mid, s3_row_ff[1].mid, s3_row_ff[2].mid);
      s4_hi_ff   <= min2(min2(s3_row_ff[0].hi, s3_row_ff[1].hi), s3_row_ff[2].hi);
      s4_med_ff  <= s3_med_ff;
      s4_last_ff <= s3_last_ff;
      s4_pass_ff <= s3_pass_ff;
   end

   // stage 4: final median or border passthrough
   assign push                  = s4_valid_ff;
   assign push_result.pixel     = s4_med_ff ? med3(s4_lo_ff, s4_mid_ff, s4_hi_ff) : s4_pass_ff;
   assign push_result.frame_end = s4_last_ff;

endmodule

### hdl/mf3_out_buf.sv
// ----------------------------------------------------------------------------
// mf3_out_buf
// Result buffer that decouples the back-end pipeline from the result channel.
// ----------------------------------------------------------------------------
module mf3_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mf3_pkg::result_type      push_result,
   input  logic                     pop,
   output mf3_pkg::result_type      head_result,
   output mf3_pkg::out_status_type  status
);

   mf3_pkg::result_type                entry_ff [mf3_pkg::OUT_DEPTH];
   logic [mf3_pkg::OUT_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [mf3_pkg::OUT_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [mf3_pkg::OUT_CNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mf3_pkg::OUT_PTR_BITS'(mf3_pkg::OUT_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + mf3_pkg::OUT_PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mf3_pkg::OUT_PTR_BITS'(mf3_pkg::OUT_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + mf3_pkg::OUT_PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + mf3_pkg::OUT_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - mf3_pkg::OUT_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_result;
      end
   end

   assign head_result      = entry_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.count     = count_ff;

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the 3x3 median filter. Random and corner-case frames go
// through the pixel channel while a scoreboard class tracks the row stores,
// the window and the drain count, and checks every output pixel in order.
// Both sides idle at random in two of three phases. One long output stall
// backs the block up, and the frame size is rewritten only between frames.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mf3_pkg::*;

   class median_scoreboard;
      logic [FW_BITS-1:0]  width_reg;
      logic [FH_BITS-1:0]  height_reg;
      bit [PIX_BITS-1:0]   row_upper [MAX_WIDTH];
      bit [PIX_BITS-1:0]   row_lower [MAX_WIDTH];
      bit [PIX_BITS-1:0]   win [9];
      int unsigned         in_col, in_row, out_col, out_row, drain_left;
      result_type          expected_pixels [$];
      int                  errors;

      function new();
         width_reg  = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         drain_left = 0;
         errors = 0;
         foreach (win[i]) win[i] = '0;
      endfunction

      function void write_register(csr_reg_type idx, logic [CSR_DATA_BITS-1:0] data);
         if (idx == REG_FRAME_WIDTH) begin
            width_reg = data[FW_BITS-1:0];
         end else begin
            height_reg = data[FH_BITS-1:0];
         end
      endfunction

      function int unsigned frame_cols();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_WIDTH) return MAX_WIDTH;
         return width_reg;
      endfunction

      function int unsigned frame_rows();
         return (height_reg == 0) ? 1 : height_reg;
      endfunction

      function void step_out(int unsigned cols);
         if (out_col + 1 >= cols) begin
            out_col = 0;
            out_row = (out_row + 1) & 16'hFFFF;
         end else begin
            out_col++;
         end
      endfunction

      function void note_item(mode_type mode, logic [PIX_BITS-1:0] px);
         int unsigned cols, rows, ic, ir, idx, below, same;
         bit [PIX_BITS-1:0] v;
         bit emit;
         result_type r;
         cols = frame_cols();
         rows = frame_rows();
         if (mode == MODE_FLUSH) begin
            if (drain_left == 0) return;
            idx = (out_col < MAX_WIDTH) ? out_col : MAX_WIDTH - 1;
            r.pixel = (out_row + 1 >= rows) ? row_lower[idx] : row_upper[idx];
            drain_left--;
            step_out(cols);
            r.frame_end = (drain_left == 0);
            if (r.frame_end) begin
               out_col = 0;
               out_row = 0;
            end
            expected_pixels.push_back(r);
            return;
         end
         // pixels during a drain are dropped
         if (drain_left != 0) return;
         ic = in_col;
         ir = in_row;
         idx = (ic < MAX_WIDTH) ? ic : MAX_WIDTH - 1;
         for (int a = 0; a < 3; a++) begin
            win[a*3]   = win[a*3+1];
            win[a*3+1] = win[a*3+2];
         end
         win[2] = row_upper[idx];
         win[5] = row_lower[idx];
         win[8] = px;
         row_upper[idx] = row_lower[idx];
         row_lower[idx] = px;
         emit = (ir >= 2) || (ir == 1 && ic >= 1);
         v = win[4];
         if (emit) begin
            if (ir >= 2 && ic >= 2 && ir < rows && ic < cols) begin
               for (int a = 0; a < 9; a++) begin
                  below = 0;
                  same = 0;
                  for (int b = 0; b < 9; b++) begin
                     if (win[b] < win[a]) below++;
                     else if (win[b] == win[a]) same++;
                  end
                  if (below <= 4 && below + same > 4) v = win[a];
               end
            end
            step_out(cols);
         end
         if (ic + 1 >= cols) begin
            in_col = 0;
            if (ir + 1 >= rows) begin
               in_row = 0;
               drain_left = (rows == 1) ? cols : cols + 1;
            end else begin
               in_row = (ir + 1) & 16'hFFFF;
            end
         end else begin
            in_col = ic + 1;
         end
         if (emit) begin
            r.pixel = v;
            r.frame_end = 1'b0;
            expected_pixels.push_back(r);
         end
      endfunction

      function void check_pixel(logic [PIX_BITS-1:0] px, logic fe);
         result_type want;
         if (expected_pixels.size() == 0) begin
            if (errors < 40)
               $display("%0t: unexpected transaction, expected none, actual %0d end %0b",
                        $time, px, fe);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         if (px !== want.pixel || fe !== want.frame_end) begin
            if (errors < 40)
               $display("%0t: expected pixel %0d end %0b, actual pixel %0d end %0b",
                        $time, want.pixel, want.frame_end, px, fe);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_mode = MODE_PIXEL;
   logic [PIX_BITS-1:0]       req_pixel_in = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [PIX_BITS-1:0]       rsp_pixel_out;
   logic                      rsp_frame_end;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_FRAME_WIDTH;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   median_scoreboard sb = new();
   int unsigned accepted_items = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;

   median_filter_3x3 u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #6 clock = ~clock;

   // output side: random stall, or a long hold when one is requested
   always begin
      @(posedge clock);
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         repeat (hold_cycles) @(posedge clock);
         hold_cycles = 0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_pixel(rsp_pixel_out, rsp_frame_end);
   end

   function automatic logic [PIX_BITS-1:0] random_pixel();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2, 3: return 8'(120 + $urandom_range(0, 15));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_item(input mode_type mode, input logic [PIX_BITS-1:0] px);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_pixel_in <= px;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
         @(posedge clock);
      end
      sb.note_item(mode, px);
      accepted_items++;
      @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
         @(posedge clock);
      end
      sb.write_register(idx, data);
      @(posedge clock);
   endtask

   task automatic set_frame(input logic [CSR_DATA_BITS-1:0] cols,
                            input logic [CSR_DATA_BITS-1:0] rows);
      write_reg(REG_FRAME_WIDTH, cols);
      write_reg(REG_FRAME_HEIGHT, rows);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_pixels.size() != 0) @(posedge clock);
   endtask

   // dropped transactions may still be in the pipe after the last output
   task automatic wait_idle();
      wait_drained();
      repeat (24) @(posedge clock);
   endtask

   task automatic run_frame(input bit noisy);
      int unsigned cols, rows, n;
      cols = sb.frame_cols();
      rows = sb.frame_rows();
      for (n = 0; n < cols * rows; n++) begin
         if (noisy && $urandom_range(0, 39) == 0) send_item(MODE_FLUSH, random_pixel());
         send_item(MODE_PIXEL, random_pixel());
      end
      for (n = 0; n < ((rows == 1) ? cols : cols + 1); n++) begin
         if (noisy && $urandom_range(0, 9) == 0) send_item(MODE_PIXEL, random_pixel());
         send_item(MODE_FLUSH, random_pixel());
      end
      if (noisy && $urandom_range(0, 3) == 0) send_item(MODE_FLUSH, random_pixel());
   endtask

   initial begin
      logic [PIX_BITS-1:0] corner_px [9];
      int unsigned target, cols, rows;
      corner_px = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'hFF, 8'h00, 8'h55};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // 3x3 frame, extreme values, pixel during drain, flush with nothing left
      set_frame(3, 3);
      foreach (corner_px[i]) send_item(MODE_PIXEL, corner_px[i]);
      send_item(MODE_PIXEL, 8'hAA);
      repeat (4) send_item(MODE_FLUSH, 8'h00);
      send_item(MODE_FLUSH, 8'hFF);
      wait_idle();

      // zero width and height act as a single pixel frame
      set_frame(0, 0);
      send_item(MODE_PIXEL, 8'hFF);
      send_item(MODE_FLUSH, 8'h00);
      send_item(MODE_FLUSH, 8'hAA);
      wait_idle();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 51 : 0;
         recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 17 : 0;
         target = accepted_items + 160;
         if (phase == 0) begin
            // long output stall while pixels keep coming
            set_frame(12, 10);
            hold_cycles = 300;
            run_frame(1'b0);
            wait_drained();
         end
         while (accepted_items < target) begin
            if ($urandom_range(0, 3) != 0) begin
               case ($urandom_range(0, 19))
                  0: cols = 0;
                  1: cols = $urandom_range(11, 40);
                  default: cols = $urandom_range(1, 10);
               endcase
               rows = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
               wait_idle();
               set_frame(CSR_DATA_BITS'(cols), CSR_DATA_BITS'(rows));
            end
            run_frame(1'b1);
            if ($urandom_range(0, 4) == 0) wait_drained();
         end
      end

      // tallest frame, left open after its first rows
      wait_idle();
      set_frame(3, 16'hFFFF);
      repeat (90) send_item(MODE_PIXEL, random_pixel());

      wait_drained();
      repeat (30) @(posedge clock);
      if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
         $display("PASS median_filter_3x3");
      end else begin
         $display("FAIL median_filter_3x3");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL median_filter_3x3");
      $finish;
   end

endmodule
